// File: hw/rtl/rt13_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rt13_pkg: shared types and constants of the rot13 translator
// Code point width, command codes, sequencer states, rotation ranges.
// ---------------------------------------------------------------------------
package rt13_pkg;

  localparam int CP_W  = 21;
  localparam int CNT_W = 3;
  localparam int IDX_W = 10;
  localparam int TS_W  = 11;
  localparam int IN_PARTS = 4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_EMIT
  } rt13_state_t;

  localparam int NUM_RANGES = 12;
  localparam logic [CP_W-1:0] RANGE_BASE [NUM_RANGES] = '{
    21'h00041, 21'h00061, 21'h0249C, 21'h024B6, 21'h024D0, 21'h0FF21,
    21'h0FF41, 21'h1F110, 21'h1F130, 21'h1F150, 21'h1F170, 21'h1F1E6
  };

  // base + (offset + 13) mod 26 inside any of the letter ranges
  function automatic logic [CP_W-1:0] rot_point(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] res;
    logic [4:0]      off;
    logic [5:0]      sum;
    res = cp;
    off = '0;
    sum = '0;
    for (int n = 0; n < NUM_RANGES; n++) begin
      if (cp >= RANGE_BASE[n] && cp < RANGE_BASE[n] + 21'd26) begin
        off = 5'(cp - RANGE_BASE[n]);
        sum = {1'b0, off} + 6'd13;
        if (sum >= 6'd26) begin
          sum = sum - 6'd26;
        end
        res = RANGE_BASE[n] + CP_W'(sum);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rt13_ifs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rt13 channel interfaces
// Valid/ready channels for items, results and the table_size register.
// ---------------------------------------------------------------------------
interface rt13_in_if import rt13_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] entry_index;
  logic [CP_W-1:0]  code_point;
  logic [CNT_W-1:0] part_count;
  logic [CP_W-1:0]  part_zero;
  logic [CP_W-1:0]  part_one;
  logic [CP_W-1:0]  part_two;
  logic [CP_W-1:0]  part_three;

  modport source (output valid, command, entry_index, code_point, part_count,
                  part_zero, part_one, part_two, part_three, input ready);
  modport sink   (input valid, command, entry_index, code_point, part_count,
                  part_zero, part_one, part_two, part_three, output ready);
endinterface

interface rt13_out_if import rt13_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] out_point;
  logic            last_of_run;

  modport source (output valid, out_point, last_of_run, input ready);
  modport sink   (input valid, out_point, last_of_run, output ready);
endinterface

interface rt13_cfg_if import rt13_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rt13_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rt13_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rt13_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/unicode_rot13_translator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// unicode_rot13_translator: rot13 over Unicode letter ranges with a
// loadable, key-sorted decomposition table searched by binary search.
//
// Channels: in_ch carries load items (command 0, one table entry) and
// translate items (command 1, one code point). out_ch returns one to four
// code points per translate item, last_of_run set on the final one.
// cfg_ch writes table_size; it is always ready, write it only when idle.
// A load gives no result and leaves the sequencer idle. A translate item
// runs a probe/compare loop over the entry RAM, each probe an address step
// and a compare of the registered read, at most ceil(log2(table_size+1))
// compares, then one code point per cycle unless the receiver stalls.
// in_ch.ready is high only while the sequencer is idle.
// Results go through an output register; if the receiver stalls, emission
// waits, and the next item is taken as soon as the final result is in
// that register. Reset clears table_size and the sequencer; the table
// RAM is not cleared and an entry must be loaded before it is searched.
// ---------------------------------------------------------------------------
module unicode_rot13_translator import rt13_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_PARTS   = 4
) (
  input wire logic clk,
  input wire logic rst_n,
  rt13_cfg_if.sink   cfg_ch,
  rt13_in_if.sink    in_ch,
  rt13_out_if.source out_ch
);

  localparam int AW         = $clog2(TABLE_DEPTH);
  localparam int PW         = AW + 1;
  localparam int CW         = (PW > TS_W) ? PW : TS_W;
  localparam int PART_LIMIT = (MAX_PARTS < IN_PARTS) ? MAX_PARTS : IN_PARTS;
  localparam int KW         = (PART_LIMIT > 2) ? 2 : 1;
  localparam int RW         = CP_W + CNT_W + CP_W * MAX_PARTS;

  rt13_state_t state_r, state_nxt;

  logic [TS_W-1:0]  ts_r;
  logic [PW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic             single_r, single_nxt;
  logic             miss_r, miss_nxt;
  logic [CP_W-1:0]  cp_r, cp_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CP_W-1:0]  parts_r [PART_LIMIT];
  logic             out_vld_r, out_vld_nxt;
  logic [CP_W-1:0]  out_pt_r, out_pt_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_xfer, load_xfer, xlate_xfer;
  logic [PW-1:0]    len;
  logic [PW-1:0]    mid_calc;
  logic [PW-1:0]    hi_init;
  logic [CP_W-1:0]  probe_key;
  logic             key_eq, key_lt;
  logic             hit;
  logic [CNT_W-1:0] rd_cnt;
  logic             push, emit_last;
  logic [CP_W-1:0]  rot_src, rot_val;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RW-1:0]    ram_wdata, ram_rdata;
  logic [CP_W-1:0]  in_parts [IN_PARTS];
  logic [CNT_W-1:0] load_cnt;

  // -------------------------------------------------------------------------
  // entry RAM: {parts, count, key}
  // -------------------------------------------------------------------------
  rt13_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_parts[0] = in_ch.part_zero;
  assign in_parts[1] = in_ch.part_one;
  assign in_parts[2] = in_ch.part_two;
  assign in_parts[3] = in_ch.part_three;

  always_comb begin
    load_cnt = in_ch.part_count;
    if (load_cnt == '0) begin
      load_cnt = CNT_W'(1);
    end else if (load_cnt > CNT_W'(PART_LIMIT)) begin
      load_cnt = CNT_W'(PART_LIMIT);
    end
  end

  assign ram_wdata[CP_W-1:0]            = in_ch.code_point;
  assign ram_wdata[CP_W+CNT_W-1:CP_W]   = load_cnt;

  // part slots past the input's four are stored as zero
  for (genvar p = 0; p < MAX_PARTS; p++) begin : g_wparts
    if (p < IN_PARTS) begin : g_in
      assign ram_wdata[CP_W+CNT_W+CP_W*p +: CP_W] = in_parts[p];
    end else begin : g_zero
      assign ram_wdata[CP_W+CNT_W+CP_W*p +: CP_W] = '0;
    end
  end

  assign ram_waddr = AW'(in_ch.entry_index);

  // -------------------------------------------------------------------------
  // search arithmetic
  // -------------------------------------------------------------------------
  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign load_xfer  = in_xfer && (in_ch.command == CMD_LOAD);
  assign xlate_xfer = in_xfer && (in_ch.command == CMD_XLATE);

  assign len      = hi_r - lo_r;
  assign mid_calc = lo_r + (len >> 1);
  assign hi_init  = (CW'(ts_r) > CW'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : PW'(ts_r);

  assign probe_key = ram_rdata[CP_W-1:0];
  assign key_eq    = (cp_r == probe_key);
  assign key_lt    = (cp_r < probe_key);
  assign hit       = (state_r == ST_CHECK) && key_eq;

  always_comb begin
    rd_cnt = ram_rdata[CP_W+CNT_W-1:CP_W];
    if (rd_cnt == '0) begin
      rd_cnt = CNT_W'(1);
    end else if (rd_cnt > CNT_W'(PART_LIMIT)) begin
      rd_cnt = CNT_W'(PART_LIMIT);
    end
  end

  // shared rotation unit: miss point or first part of a hit
  assign rot_src   = miss_r ? cp_r : parts_r[k_r];
  assign rot_val   = (miss_r || k_r == '0) ? rot_point(rot_src) : rot_src;
  assign emit_last = miss_r || (CNT_W'(k_r) + CNT_W'(1) == cnt_r);
  assign push      = (state_r == ST_EMIT) && (!out_vld_r || out_ch.ready);

  // -------------------------------------------------------------------------
  // next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (xlate_xfer) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = (len == '0) ? ST_EMIT : ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (key_eq || single_r) ? ST_EMIT : ST_PROBE;
      end
      ST_EMIT: begin
        if (push && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // outputs of the sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = mid_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_we      = in_ch.valid && (in_ch.command == CMD_LOAD) &&
                      (CW'(in_ch.entry_index) < CW'(TABLE_DEPTH));
      end
      ST_PROBE: begin
        ram_raddr = AW'(mid_calc);
      end
      ST_CHECK, ST_EMIT: begin
        ram_raddr = mid_r;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_point   = out_pt_r;
  assign out_ch.last_of_run = out_last_r;

  // -------------------------------------------------------------------------
  // datapath next values
  // -------------------------------------------------------------------------
  always_comb begin
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    single_nxt   = single_r;
    miss_nxt     = miss_r;
    cp_nxt       = cp_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    out_pt_nxt   = out_pt_r;
    out_last_nxt = out_last_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (xlate_xfer) begin
          cp_nxt = in_ch.code_point;
          lo_nxt = '0;
          hi_nxt = hi_init;
          k_nxt  = '0;
        end
      end
      ST_PROBE: begin
        if (len == '0) begin
          miss_nxt = 1'b1;
        end else begin
          mid_nxt    = AW'(mid_calc);
          single_nxt = (len == PW'(1));
        end
      end
      ST_CHECK: begin
        if (key_eq) begin
          miss_nxt = 1'b0;
          cnt_nxt  = rd_cnt;
        end else if (single_r) begin
          miss_nxt = 1'b1;
        end else if (key_lt) begin
          hi_nxt = PW'(mid_r);
        end else begin
          lo_nxt = PW'(mid_r) + PW'(1);
        end
      end
      ST_EMIT: begin
        if (push) begin
          out_vld_nxt  = 1'b1;
          out_pt_nxt   = rot_val;
          out_last_nxt = emit_last;
          k_nxt        = k_r + KW'(1);
        end
      end
      default: begin
        miss_nxt = 1'b1;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ts_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        ts_r <= cfg_ch.table_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    single_r   <= single_nxt;
    miss_r     <= miss_nxt;
    cp_r       <= cp_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    out_pt_r   <= out_pt_nxt;
    out_last_r <= out_last_nxt;
    if (hit) begin
      for (int i = 0; i < PART_LIMIT; i++) begin
        parts_r[i] <= ram_rdata[CP_W+CNT_W+CP_W*i +: CP_W];
      end
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE || state_r == ST_CHECK) |-> lo_r <= hi_r)
    else $error("search range inverted");

  a_range_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE || state_r == ST_CHECK) |-> hi_r <= PW'(TABLE_DEPTH))
    else $error("search range beyond table");

  a_xlate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    xlate_xfer |=> !in_ch.ready)
    else $error("ready after translate transfer");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_xfer |=> state_r == ST_IDLE)
    else $error("load left idle");

endmodule
`default_nettype wire
